// ===== rtl/mpra_pkg.sv =====
// Shared types, constants and codes for the pooled block allocator.
`default_nettype none

package mpra_pkg;

  // Defaults for the top-level parameters
  localparam int POOLS_DEF      = 4;
  localparam int BLOCKS_DEF     = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Per-block header added to every allocate request
  localparam int HEADER_BYTES = 16;

  // Configuration register file: four size registers, then four watermarks
  localparam int SIZE_REGS = 4;
  localparam int SIZE_W    = 16;
  localparam int TOTAL_W   = SIZE_W + 1;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int REG_SEL_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PCT_BASE = 3'd4;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_OFF   = 7'd101;
  localparam int               PCT_SCALE = 100;

  typedef enum logic [2:0] {
    MODE_ALLOC      = 3'd0,
    MODE_ADD_REF    = 3'd1,
    MODE_DROP_REF   = 3'd2,
    MODE_READ_COUNT = 3'd3,
    MODE_USAGE      = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_REQ    = 3'd1,
    ST_NO_MEM     = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_BAD_HANDLE = 3'd4,
    ST_COUNT_FULL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_EXEC,
    S_DONE
  } state_t;

  // Request item
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] req_bytes;
    logic        has_handle;
    logic [1:0]  handle_pool;
    logic [3:0]  handle_slot;
  } req_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  out_pool;
    logic [3:0]  out_slot;
    logic [15:0] refs;
    logic        freed;
    logic [4:0]  used_blocks;
    logic [4:0]  total_blocks;
    logic        alarm_hit;
    logic [6:0]  alarm_pct;
  } rsp_t;

  // Update command for the slot occupancy map
  typedef struct packed {
    logic claim;
    logic drop;
  } map_op_t;

endpackage

`default_nettype wire

// ===== rtl/mpra_count_ram.sv =====
// Reference count memory: one write port, one registered read port.
`default_nettype none

module mpra_count_ram #(
  parameter int  DEPTH = 64,
  parameter int  WIDTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             write,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (write) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mpra_slot_map.sv =====
// Slot occupancy bits, per-pool usage counters and lowest-free-slot search.
`default_nettype none

module mpra_slot_map #(
  parameter int  POOLS           = 4,
  parameter int  BLOCKS_PER_POOL = 16,
  localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1,
  localparam int SW = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1,
  localparam int UW = $clog2(BLOCKS_PER_POOL + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  mpra_pkg::map_op_t op,
  input  logic [PW-1:0]     pool,
  input  logic [SW-1:0]     slot,
  output logic              busy,
  output logic [UW-1:0]     used,
  output logic              free_found,
  output logic [SW-1:0]     free_slot
);

  import mpra_pkg::*;

  logic [BLOCKS_PER_POOL-1:0] occ [POOLS];
  logic [UW-1:0]              cnt [POOLS];
  logic [BLOCKS_PER_POOL-1:0] row;
  logic                       pool_ok;

  // Select the addressed pool; pools past the end read as empty
  always_comb begin
    pool_ok = (int'(pool) < POOLS);
    row     = pool_ok ? occ[pool] : '0;
    used    = pool_ok ? cnt[pool] : '0;
    busy    = row[slot];
  end

  // Find the lowest free slot of the addressed pool
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = BLOCKS_PER_POOL - 1; s >= 0; s--) begin
      if (!row[s]) begin
        free_found = 1'b1;
        free_slot  = SW'(s);
      end
    end
  end

  // Claim or drop a slot and track the pool's usage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOLS; p++) begin
        occ[p] <= '0;
        cnt[p] <= '0;
      end
    end else if (op.claim) begin
      occ[pool][slot] <= 1'b1;
      cnt[pool]       <= cnt[pool] + UW'(1);
    end else if (op.drop) begin
      occ[pool][slot] <= 1'b0;
      if (cnt[pool] != '0) begin
        cnt[pool] <= cnt[pool] - UW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_pool_refcount_block_allocator_unit.sv =====
// Top level of the reference-counted block allocator over fixed pools.
//
// One request is worked at a time. A count request (add, drop, read), a usage
// request or a rejected request holds the request port while the slot's count
// is read from the count memory, updated and formed into a result, and the
// result handed to the output register. An allocate holds it while the size
// comparator visits the pools, then, if one is placed, while its slot is
// claimed, and then until its result is handed over. The comparator visits
// one pool per cycle, first fitting pool with a free slot wins, at most POOLS.
// A result waiting on a stalled output holds the next request off.
// Slot occupancy lives in flip-flops cleared by reset, so no clearing pass is
// needed and the block takes requests right after reset.
`default_nettype none

module multi_pool_refcount_block_allocator_unit #(
  parameter int POOLS           = mpra_pkg::POOLS_DEF,
  parameter int BLOCKS_PER_POOL = mpra_pkg::BLOCKS_DEF,
  parameter int COUNT_BITS      = mpra_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  mpra_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output mpra_pkg::rsp_t                 rsp,
  input  logic                           cfg_write,
  input  logic [mpra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpra_pkg::SIZE_W-1:0]    cfg_data
);

  import mpra_pkg::*;

  localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int SW    = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
  localparam int UW    = $clog2(BLOCKS_PER_POOL + 1);
  localparam int DEPTH = POOLS * BLOCKS_PER_POOL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AMW   = UW + PCT_W;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state, state_next;

  req_t                 cur;
  logic [TOTAL_W-1:0]   cur_total;
  logic [PW-1:0]        cur_pool, pool_next;
  logic [SW-1:0]        cur_slot, slot_next;
  rsp_t                 res, res_next;

  logic [SIZE_W-1:0]    pool_bytes [SIZE_REGS];
  logic [PCT_W-1:0]     pool_pct   [SIZE_REGS];
  logic [POOLS-1:0]     alarm_fired;

  logic                 req_accept;
  logic                 rsp_load;
  logic                 fire;
  logic                 handle_ok;
  logic                 last_pool;
  logic                 fits;
  logic [SIZE_W-1:0]    size_sel;
  logic [PCT_W-1:0]     pct_sel;
  logic [UW-1:0]        used_inc;
  logic [UW-1:0]        used_after;
  logic [AMW-1:0]       alarm_lhs;
  logic [AMW-1:0]       alarm_rhs;

  map_op_t              map_op;
  logic                 map_busy;
  logic [UW-1:0]        map_used;
  logic                 map_found;
  logic [SW-1:0]        map_free_slot;

  logic                 mem_write;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_now;
  logic [COUNT_BITS-1:0] cnt_new;

  mpra_slot_map #(
    .POOLS           (POOLS),
    .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
  ) u_slot_map (
    .clk        (clk),
    .rst        (rst),
    .op         (map_op),
    .pool       (cur_pool),
    .slot       (cur_slot),
    .busy       (map_busy),
    .used       (map_used),
    .free_found (map_found),
    .free_slot  (map_free_slot)
  );

  mpra_count_ram #(
    .DEPTH (DEPTH),
    .WIDTH (COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .write (mem_write),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (cnt_rd)
  );

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;

  // Count memory addresses: read the handle's slot on transfer, write the current one
  assign mem_raddr = AW'(int'(req.handle_pool) * BLOCKS_PER_POOL + int'(req.handle_slot));
  assign mem_waddr = AW'(int'(cur_pool) * BLOCKS_PER_POOL + int'(cur_slot));

  // Free slots read as a zero count whatever the memory holds
  assign cnt_now = map_busy ? cnt_rd : '0;

  assign handle_ok = cur.has_handle && (int'(cur.handle_pool) < POOLS) &&
                     (int'(cur.handle_slot) < BLOCKS_PER_POOL);

  // Pool size and watermark of the pool under the comparator
  always_comb begin
    size_sel = '0;
    pct_sel  = PCT_OFF;
    for (int k = 0; k < SIZE_REGS; k++) begin
      if (int'(cur_pool) == k) begin
        size_sel = pool_bytes[k];
        pct_sel  = pool_pct[k];
      end
    end
  end

  assign fits      = (cur_total <= TOTAL_W'(size_sel));
  assign last_pool = (int'(cur_pool) == POOLS - 1);
  assign used_inc  = map_used + UW'(1);
  assign alarm_lhs = AMW'(used_inc) * AMW'(PCT_SCALE);
  assign alarm_rhs = AMW'(pct_sel) * AMW'(BLOCKS_PER_POOL);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, memory and map commands, result fields
  always_comb begin
    state_next = state;
    pool_next  = cur_pool;
    slot_next  = cur_slot;
    res_next   = res;
    map_op     = '0;
    mem_write  = 1'b0;
    mem_wdata  = '0;
    cnt_new    = cnt_now;
    used_after = map_used;
    fire       = 1'b0;
    rsp_load   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          res_next  = '0;
          slot_next = SW'(req.handle_slot);
          if (req.mode == MODE_ALLOC && req.req_bytes != '0) begin
            pool_next  = '0;
            state_next = S_SCAN;
          end else begin
            pool_next  = PW'(req.handle_pool);
            state_next = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        // Visit one pool per cycle; full fitting pools pass the scan on
        if (fits && map_found) begin
          slot_next  = map_free_slot;
          state_next = S_COMMIT;
        end else if (last_pool) begin
          res_next.status = fits ? ST_NO_MEM : ST_TOO_LARGE;
          state_next      = S_DONE;
        end else begin
          pool_next = cur_pool + PW'(1);
        end
      end

      S_COMMIT: begin
        map_op.claim          = 1'b1;
        mem_write             = 1'b1;
        mem_wdata             = COUNT_BITS'(1);
        res_next.status       = ST_OK;
        res_next.out_pool     = 2'(cur_pool);
        res_next.out_slot     = 4'(cur_slot);
        res_next.refs         = 16'(1);
        res_next.used_blocks  = 5'(used_inc);
        res_next.total_blocks = 5'(BLOCKS_PER_POOL);
        // Fire the watermark once until it is rewritten
        if (pct_sel <= PCT_FULL && !alarm_fired[cur_pool] && alarm_lhs >= alarm_rhs) begin
          fire               = 1'b1;
          res_next.alarm_hit = 1'b1;
          res_next.alarm_pct = pct_sel;
        end
        state_next = S_DONE;
      end

      S_EXEC: begin
        case (cur.mode) inside
          MODE_ADD_REF, MODE_DROP_REF, MODE_READ_COUNT: begin
            if (cur.mode == MODE_DROP_REF && !cur.has_handle) begin
              res_next.status = ST_OK;
            end else if (!handle_ok) begin
              res_next.status = ST_BAD_HANDLE;
            end else if (cur.mode != MODE_READ_COUNT && cnt_now == '0) begin
              res_next.status = ST_BAD_HANDLE;
            end else begin
              res_next.out_pool     = cur.handle_pool;
              res_next.out_slot     = cur.handle_slot;
              res_next.total_blocks = 5'(BLOCKS_PER_POOL);
              if (cur.mode == MODE_ADD_REF) begin
                if (cnt_now == CNT_MAX) begin
                  res_next.status = ST_COUNT_FULL;
                end else begin
                  cnt_new   = cnt_now + COUNT_BITS'(1);
                  mem_write = 1'b1;
                end
              end else if (cur.mode == MODE_DROP_REF) begin
                cnt_new   = cnt_now - COUNT_BITS'(1);
                mem_write = 1'b1;
                if (cnt_new == '0) begin
                  res_next.freed = 1'b1;
                  map_op.drop    = 1'b1;
                  if (map_used != '0) begin
                    used_after = map_used - UW'(1);
                  end
                end
              end
              mem_wdata            = cnt_new;
              res_next.refs        = 16'(cnt_new);
              res_next.used_blocks = 5'(used_after);
            end
          end
          MODE_USAGE: begin
            if (int'(cur.handle_pool) >= POOLS) begin
              res_next.status = ST_BAD_REQ;
            end else begin
              res_next.out_pool     = cur.handle_pool;
              res_next.used_blocks  = 5'(map_used);
              res_next.total_blocks = 5'(BLOCKS_PER_POOL);
            end
          end
          default: begin
            res_next.status = ST_BAD_REQ;
          end
        endcase
        state_next = S_DONE;
      end

      S_DONE: begin
        // Hand the result over once the output register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    if (req_accept) begin
      cur       <= req;
      cur_total <= TOTAL_W'(req.req_bytes) + TOTAL_W'(HEADER_BYTES);
    end
    if (rst) begin
      cur_pool <= '0;
      cur_slot <= '0;
    end else begin
      cur_pool <= pool_next;
      cur_slot <= slot_next;
    end
    res      <= res_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SIZE_REGS; k++) begin
        pool_bytes[k] <= '0;
        pool_pct[k]   <= PCT_OFF;
      end
    end else if (cfg_write) begin
      if (cfg_index < CFG_PCT_BASE) begin
        pool_bytes[REG_SEL_W'(cfg_index)] <= cfg_data;
      end else begin
        pool_pct[REG_SEL_W'(cfg_index - CFG_PCT_BASE)] <= cfg_data[PCT_W-1:0];
      end
    end
  end

  // Watermark flags: set on firing, rearm on a watermark write
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_fired <= '0;
    end else begin
      for (int k = 0; k < POOLS; k++) begin
        if (fire && int'(cur_pool) == k) begin
          alarm_fired[k] <= 1'b1;
        end
        if (cfg_write && cfg_index >= CFG_PCT_BASE &&
            int'(REG_SEL_W'(cfg_index - CFG_PCT_BASE)) == k) begin
          alarm_fired[k] <= 1'b0;
        end
      end
    end
  end

  // A committed allocation leaves its slot marked busy
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |=> map_busy)
    else $error("allocated slot not marked busy");

  // The pool scan never runs past the last pool
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (int'(cur_pool) < POOLS))
    else $error("pool scan past last pool");

  // A release always reports success with a zero count
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.freed) |-> (rsp.status == ST_OK && rsp.refs == '0))
    else $error("freed result with bad status or count");

  // Watermark results come only from successful allocations within range
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.alarm_hit) |-> (rsp.status == ST_OK && rsp.alarm_pct <= PCT_FULL))
    else $error("watermark reported out of range");

  // Pool usage never exceeds the pool's block count
  assert property (@(posedge clk) disable iff (rst)
    map_used <= UW'(BLOCKS_PER_POOL))
    else $error("pool usage overflow");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pooled reference-counted block allocator.
`default_nettype none

module tb;
  import mpra_pkg::*;

  localparam int POOLS       = POOLS_DEF;
  localparam int BLOCKS      = BLOCKS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 150;
  localparam int PRINT_CAP   = 40;
  localparam int REQ_W       = $bits(req_t);

  // Mode codes the block does not implement
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // One directed request, with its result spelled out where it is obvious
  typedef struct packed {
    req_t rq;
    logic exact;
    rsp_t ex;
  } row_t;

  localparam rsp_t R_NONE       = '0;
  localparam rsp_t R_BAD_REQ    = '{status: ST_BAD_REQ, default: '0};
  localparam rsp_t R_TOO_LARGE  = '{status: ST_TOO_LARGE, default: '0};
  localparam rsp_t R_BAD_HANDLE = '{status: ST_BAD_HANDLE, default: '0};

  // Requests against the reset configuration: every pool has size zero
  localparam row_t AT_RESET [12] = '{
    '{'{MODE_ALLOC, 16'd100, 1'b0, 2'd0, 4'd0}, 1'b1, R_TOO_LARGE},
    '{'{MODE_ALLOC, 16'd0, 1'b1, 2'd3, 4'd15}, 1'b1, R_BAD_REQ},
    '{'{MODE_USAGE, 16'd0, 1'b0, 2'd2, 4'd0}, 1'b1,
      '{status: ST_OK, out_pool: 2'd2, total_blocks: 5'd16, default: '0}},
    '{'{MODE_READ_COUNT, 16'hFFFF, 1'b1, 2'd3, 4'd15}, 1'b1,
      '{status: ST_OK, out_pool: 2'd3, out_slot: 4'd15, total_blocks: 5'd16, default: '0}},
    '{'{MODE_ADD_REF, 16'd0, 1'b1, 2'd1, 4'd7}, 1'b1, R_BAD_HANDLE},
    '{'{MODE_DROP_REF, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b1, R_BAD_HANDLE},
    '{'{MODE_DROP_REF, 16'd0, 1'b0, 2'd1, 4'd3}, 1'b1, R_NONE},
    '{'{MODE_ADD_REF, 16'd0, 1'b0, 2'd0, 4'd0}, 1'b1, R_BAD_HANDLE},
    '{'{MODE_READ_COUNT, 16'd0, 1'b0, 2'd2, 4'd9}, 1'b1, R_BAD_HANDLE},
    '{'{MODE_SPARE5, 16'd64, 1'b1, 2'd0, 4'd0}, 1'b1, R_BAD_REQ},
    '{'{MODE_SPARE6, 16'd0, 1'b0, 2'd0, 4'd0}, 1'b1, R_BAD_REQ},
    '{'{MODE_SPARE7, 16'hFFFF, 1'b1, 2'd3, 4'd15}, 1'b1, R_BAD_REQ}
  };

  // Requests with pool sizes 64, 256, 1024, 65535 and watermarks 50, 100, 0, off
  localparam row_t FIRST_POOLS [16] = '{
    '{'{MODE_ALLOC, 16'd0, 1'b0, 2'd0, 4'd0}, 1'b1, R_BAD_REQ},
    '{'{MODE_ALLOC, 16'd48, 1'b0, 2'd0, 4'd0}, 1'b1,
      '{status: ST_OK, refs: 16'd1, used_blocks: 5'd1, total_blocks: 5'd16,
        default: '0}},
    '{'{MODE_ALLOC, 16'd49, 1'b0, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_ALLOC, 16'd65519, 1'b0, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_ALLOC, 16'd65520, 1'b0, 2'd0, 4'd0}, 1'b1, R_TOO_LARGE},
    '{'{MODE_ALLOC, 16'hFFFF, 1'b1, 2'd3, 4'd15}, 1'b1, R_TOO_LARGE},
    '{'{MODE_ALLOC, 16'd1000, 1'b0, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_ALLOC, 16'd1008, 1'b0, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_ALLOC, 16'd1009, 1'b0, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_ADD_REF, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_READ_COUNT, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_DROP_REF, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_DROP_REF, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_DROP_REF, 16'd0, 1'b1, 2'd0, 4'd0}, 1'b1, R_BAD_HANDLE},
    '{'{MODE_USAGE, 16'd0, 1'b0, 2'd3, 4'd0}, 1'b0, R_NONE},
    '{'{MODE_READ_COUNT, 16'd0, 1'b1, 2'd3, 4'd15}, 1'b0, R_NONE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  // Allocator mirror: slot counts, pool usage, watermark state and registers
  logic [15:0] refs_now [POOLS*BLOCKS];
  logic [4:0] used_now [POOLS];
  bit fired_now [POOLS];
  logic [SIZE_W-1:0] blk_bytes [POOLS];
  logic [PCT_W-1:0] alarm_at [POOLS];

  rsp_t awaited [$];
  rsp_t due;
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  multi_pool_refcount_block_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  // Advance the mirror by one request and return the result it should give
  function automatic rsp_t predict_response(input req_t r);
    rsp_t o;
    logic [16:0] need;
    logic [15:0] cnt;
    logic [5:0] idx;
    int p;
    int s;
    int fit;
    int usage;
    bit placed;
    o = '0;
    idx = {r.handle_pool, r.handle_slot};
    case (r.mode)
      MODE_ALLOC: begin
        need = 17'(r.req_bytes) + 17'(HEADER_BYTES);
        if (r.req_bytes == '0) begin
          o.status = ST_BAD_REQ;
        end else begin
          placed = 1'b0;
          for (p = 0; p < POOLS && !placed; p++) begin
            if (need <= 17'(blk_bytes[p])) begin
              fit = -1;
              for (s = BLOCKS - 1; s >= 0; s--)
                if (refs_now[p*BLOCKS+s] == '0) fit = s;
              if (fit >= 0) begin
                placed = 1'b1;
                refs_now[p*BLOCKS+fit] = 16'd1;
                used_now[p] = used_now[p] + 5'd1;
                o.out_pool = 2'(p);
                o.out_slot = 4'(fit);
                o.refs = 16'd1;
                o.used_blocks = used_now[p];
                o.total_blocks = 5'(BLOCKS);
                // fire the watermark once per arming
                if (alarm_at[p] <= PCT_FULL && !fired_now[p]) begin
                  usage = int'(used_now[p]) * PCT_SCALE / BLOCKS;
                  if (usage >= int'(alarm_at[p])) begin
                    fired_now[p] = 1'b1;
                    o.alarm_hit = 1'b1;
                    o.alarm_pct = alarm_at[p];
                  end
                end
              end else if (p == POOLS - 1) begin
                o.status = ST_NO_MEM;
              end
            end else if (p == POOLS - 1) begin
              o.status = ST_TOO_LARGE;
            end
          end
        end
      end
      MODE_ADD_REF, MODE_DROP_REF, MODE_READ_COUNT: begin
        if (r.mode == MODE_DROP_REF && !r.has_handle) begin
          o.status = ST_OK;
        end else if (!r.has_handle) begin
          o.status = ST_BAD_HANDLE;
        end else if (r.mode != MODE_READ_COUNT && refs_now[idx] == '0) begin
          o.status = ST_BAD_HANDLE;
        end else begin
          cnt = refs_now[idx];
          if (r.mode == MODE_ADD_REF) begin
            if (cnt == '1) o.status = ST_COUNT_FULL;
            else cnt = cnt + 16'd1;
          end else if (r.mode == MODE_DROP_REF) begin
            cnt = cnt - 16'd1;
            if (cnt == '0) begin
              o.freed = 1'b1;
              if (used_now[r.handle_pool] != '0)
                used_now[r.handle_pool] = used_now[r.handle_pool] - 5'd1;
            end
          end
          refs_now[idx] = cnt;
          o.out_pool = r.handle_pool;
          o.out_slot = r.handle_slot;
          o.refs = cnt;
          o.used_blocks = used_now[r.handle_pool];
          o.total_blocks = 5'(BLOCKS);
        end
      end
      MODE_USAGE: begin
        o.out_pool = r.handle_pool;
        o.used_blocks = used_now[r.handle_pool];
        o.total_blocks = 5'(BLOCKS);
      end
      default: o.status = ST_BAD_REQ;
    endcase
    return o;
  endfunction

  // Offer one request after a random gap and hold it until the transfer
  task automatic offer(input req_t r, input logic exact, input rsp_t want);
    int gap;
    rsp_t got;
    gap = 0;
    if (!quiet) begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  gap = 0;
        [55:84]: gap = $urandom_range(1, 3);
        [85:96]: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(20, 60);
      endcase
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = predict_response(r);
    awaited.push_back(exact ? want : got);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all eight registers back to back, sizes first
  task automatic program_regs(input logic [SIZE_W-1:0] sizes [POOLS],
                              input logic [PCT_W-1:0] pcts [POOLS]);
    int i;
    for (i = 0; i < POOLS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= sizes[i];
      blk_bytes[i] = sizes[i];
      @(posedge clk);
    end
    for (i = 0; i < POOLS; i++) begin
      cfg_index <= CFG_PCT_BASE + CFG_IDX_W'(i);
      cfg_data <= SIZE_W'(pcts[i]);
      alarm_at[i] = pcts[i];
      fired_now[i] = 1'b0;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Random traffic: allocations, count changes on live blocks, queries, noise
  task automatic run_random(input int count, input int alloc_pct);
    req_t r;
    int n;
    int i;
    int p;
    int lim;
    int live [$];
    for (n = 0; n < count; n++) begin
      r = req_t'(REQ_W'($urandom));
      live.delete();
      for (i = 0; i < POOLS * BLOCKS; i++)
        if (refs_now[i] != '0) live.push_back(i);
      if ($urandom_range(0, 99) < alloc_pct) begin
        r.mode = MODE_ALLOC;
        p = $urandom_range(0, POOLS - 1);
        lim = (blk_bytes[p] > HEADER_BYTES) ? int'(blk_bytes[p]) - HEADER_BYTES : 1;
        case ($urandom_range(0, 19))
          0: r.req_bytes = '0;
          1: r.req_bytes = 16'hFFFF;
          2: r.req_bytes = 16'($urandom);
          3, 4: r.req_bytes = 16'(lim);
          5: r.req_bytes = 16'(lim + 1);
          default: r.req_bytes = 16'($urandom_range(1, lim));
        endcase
      end else begin
        i = (live.size() != 0) ? live[$urandom_range(0, live.size() - 1)] : -1;
        case ($urandom_range(0, 99)) inside
          [0:29]:  r.mode = MODE_ADD_REF;
          [30:64]: r.mode = MODE_DROP_REF;
          [65:79]: r.mode = MODE_READ_COUNT;
          [80:87]: r.mode = MODE_USAGE;
          default: i = -1;
        endcase
        // aim count requests at a live block; noise keeps its random fields
        if (i >= 0 && r.mode != MODE_USAGE) begin
          r.has_handle = 1'b1;
          {r.handle_pool, r.handle_slot} = 6'(i);
        end
      end
      offer(r, 1'b0, R_NONE);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always begin : rsp_side
    int run;
    @(posedge clk);
    if (hold_off) begin
      rsp_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end else if (quiet) begin
      rsp_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          rsp_stall <= 1'b0;
          run = $urandom_range(1, 8);
        end
        [55:89]: begin
          rsp_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end
        [90:96]: begin
          rsp_stall <= 1'b1;
          run = $urandom_range(4, 12);
        end
        default: begin
          rsp_stall <= 1'b1;
          run = $urandom_range(20, 50);
        end
      endcase
      repeat (run - 1) @(posedge clk);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited.size() == 0) begin
        report("result with nothing pending, status", int'(rsp.status), -1);
      end else begin
        due = awaited.pop_front();
        if (rsp.status !== due.status)
          report("status", int'(rsp.status), int'(due.status));
        if (rsp.out_pool !== due.out_pool)
          report("out_pool", int'(rsp.out_pool), int'(due.out_pool));
        if (rsp.out_slot !== due.out_slot)
          report("out_slot", int'(rsp.out_slot), int'(due.out_slot));
        if (rsp.refs !== due.refs)
          report("refs", int'(rsp.refs), int'(due.refs));
        if (rsp.freed !== due.freed)
          report("freed", int'(rsp.freed), int'(due.freed));
        if (rsp.used_blocks !== due.used_blocks)
          report("used_blocks", int'(rsp.used_blocks), int'(due.used_blocks));
        if (rsp.total_blocks !== due.total_blocks)
          report("total_blocks", int'(rsp.total_blocks), int'(due.total_blocks));
        if (rsp.alarm_hit !== due.alarm_hit)
          report("alarm_hit", int'(rsp.alarm_hit), int'(due.alarm_hit));
        if (rsp.alarm_pct !== due.alarm_pct)
          report("alarm_pct", int'(rsp.alarm_pct), int'(due.alarm_pct));
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    int i;
    int hot;
    req_t r;
    for (i = 0; i < POOLS * BLOCKS; i++) refs_now[i] = '0;
    for (i = 0; i < POOLS; i++) begin
      used_now[i] = '0;
      fired_now[i] = 1'b0;
      blk_bytes[i] = '0;
      alarm_at[i] = PCT_OFF;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset configuration
    for (i = 0; i < $size(AT_RESET); i++)
      offer(AT_RESET[i].rq, AT_RESET[i].exact, AT_RESET[i].ex);
    settle();

    // directed: first pool layout, then random with a long receiver hold-off
    program_regs('{16'd64, 16'd256, 16'd1024, 16'hFFFF}, '{7'd50, PCT_FULL, 7'd0, PCT_OFF});
    for (i = 0; i < $size(FIRST_POOLS); i++)
      offer(FIRST_POOLS[i].rq, FIRST_POOLS[i].exact, FIRST_POOLS[i].ex);
    hold_off = 1'b1;
    run_random(300, 45);
    settle();

    // every pool at the largest size: fill all of them up to no-memory
    program_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                 '{PCT_FULL, PCT_FULL, PCT_FULL, PCT_FULL});
    run_random(350, 85);
    settle();

    // uneven sizes: a full middle pool falls through to a last pool too small
    program_regs('{16'd32, 16'd17, 16'd4096, 16'd200}, '{7'd25, 7'd1, 7'd75, PCT_OFF});
    run_random(300, 55);
    settle();

    // no pool fits: mostly drains blocks held from earlier phases
    program_regs('{16'd0, 16'd0, 16'd0, 16'd0}, '{7'd0, 7'd0, 7'd0, 7'd0});
    run_random(150, 20);
    settle();

    // back-to-back stretch with no idling on either side
    quiet = 1'b1;
    program_regs('{16'd100, 16'd1000, 16'd10000, 16'hFFFF}, '{7'd90, 7'd60, 7'd30, 7'd6});
    run_random(300, 50);
    settle();
    quiet = 1'b0;

    program_regs('{16'd20, 16'd40, 16'd60, 16'd80},
                 '{7'($urandom_range(0, 101)), 7'($urandom_range(0, 101)),
                   7'($urandom_range(0, 101)), 7'($urandom_range(0, 101))});
    run_random(400, 40);
    settle();

    // raise one block's count a few steps back to back, then release one
    quiet = 1'b1;
    program_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                 '{PCT_OFF, PCT_OFF, PCT_OFF, PCT_OFF});
    r = '0;
    r.mode = MODE_ALLOC;
    r.req_bytes = 16'd1;
    offer(r, 1'b0, R_NONE);
    hot = 0;
    for (i = 0; i < POOLS * BLOCKS; i++)
      if (refs_now[i] != '0) hot = i;
    r.mode = MODE_ADD_REF;
    r.has_handle = 1'b1;
    {r.handle_pool, r.handle_slot} = 6'(hot);
    repeat (8) offer(r, 1'b0, R_NONE);
    r.mode = MODE_DROP_REF;
    offer(r, 1'b0, R_NONE);
    settle();
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
